// ----- hw/rtl/lbfp_pkg.sv -----
// Package for the LSB-first bit-field packer: command codes, field widths
// and parameter defaults. No dependencies.
`default_nettype none
package lbfp_pkg;

    localparam int STORE_BYTES_DEF    = 4096;
    localparam int MAX_FIELD_BITS_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 64;
    localparam int WIDTH_W = 7;
    localparam int POS_W   = 16;

    // Store word and funnel shifter geometry.
    localparam int WORD_W  = 64;
    localparam int OFF_W   = 6;
    localparam int SHAMT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ALIGN = 2'd2,
        CMD_SET   = 2'd3
    } t_cmd;

endpackage
`default_nettype wire

// ----- hw/rtl/lbfp_in_if.sv -----
// Valid/ready channels of the bit-field packer: command words in and
// result words out. Depends on lbfp_pkg.
`default_nettype none
interface lbfp_in_if;
    import lbfp_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] field_value;
    logic [WIDTH_W-1:0] field_width;
    logic [POS_W-1:0]   new_position;

    modport source (output valid, command, field_value, field_width, new_position,
                    input ready);
    modport sink   (input valid, command, field_value, field_width, new_position,
                    output ready);
endinterface

interface lbfp_out_if;
    import lbfp_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   cursor_position;
    logic               status;

    modport source (output valid, read_value, cursor_position, status, input ready);
    modport sink   (input valid, read_value, cursor_position, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lbfp_funnel.sv -----
// Shared funnel shifter: takes a double word and returns the word that
// starts at the given bit. Depends on lbfp_pkg.
`default_nettype none
module lbfp_funnel (
    input  wire logic [2*lbfp_pkg::WORD_W-1:0] i_din,
    input  wire logic [lbfp_pkg::SHAMT_W-1:0]  i_shamt,
    output logic      [lbfp_pkg::WORD_W-1:0]   o_dout
);
    import lbfp_pkg::*;

    logic [2*WORD_W-1:0] shifted;

    assign shifted = i_din >> i_shamt;
    assign o_dout  = shifted[WORD_W-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/lbfp_store.sv -----
// Word store of the bit-field packer: one write port and one read port,
// read data registered. Depends on lbfp_pkg.
`default_nettype none
module lbfp_store #(
    parameter int DEPTH = lbfp_pkg::STORE_BYTES_DEF / 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [lbfp_pkg::WORD_W-1:0] i_wdata,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [lbfp_pkg::WORD_W-1:0] o_rdata
);
    import lbfp_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lsb_first_bit_field_packer.sv -----
// Top level of the LSB-first bit-field packer: sequencer, cursor, output
// register. Depends on lbfp_pkg, lbfp_in_if, lbfp_store and lbfp_funnel.
`default_nettype none
//
//  Channel   Direction  Word contents
//  i_cmd     in         command, field_value, field_width, new_position
//  o_res     out        read_value, cursor_position, status
//
// A write goes through S_WR0, and S_WR1 when the field straddles two 64-bit
// store words, to S_DONE; the single ports of the store and the shared
// funnel shifter set this. A read goes through S_RD1 and S_EXT; align,
// set-cursor, zero-width and overflow commands go straight to S_DONE.
// After reset the store is cleared one word a cycle, all STORE_BYTES/8 words
// (rounded up), with i_cmd.ready low. A result that waits on o_res does not
// stop the next word from being accepted; it stalls only the finishing step.
//
module lsb_first_bit_field_packer #(
    parameter int STORE_BYTES    = lbfp_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = lbfp_pkg::MAX_FIELD_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lbfp_in_if.sink     i_cmd,
    lbfp_out_if.source  o_res
);
    import lbfp_pkg::*;

    // Store geometry: the byte stream is packed into 64-bit words, bit p of
    // the stream is bit (p mod 64) of word (p div 64).
    localparam int NWORDS  = (STORE_BYTES + 7) / 8;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CAP     = STORE_BYTES * 8;
    localparam int CW      = $clog2(CAP + 1);
    localparam int PW      = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_WR0  = 7'b0000100,
        S_WR1  = 7'b0001000,
        S_RD1  = 7'b0010000,
        S_EXT  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]      r_clr;
    logic [CW-1:0]      r_cursor;
    logic [AW-1:0]      r_addr;
    logic [OFF_W-1:0]   r_off;
    logic               r_need;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_mask;
    logic [WORD_W-1:0]  r_lo;
    logic [VALUE_W-1:0] r_rd;
    logic               r_st;

    logic               r_ov;
    logic [VALUE_W-1:0] r_o_read;
    logic [POS_W-1:0]   r_o_cursor;
    logic               r_o_status;

    // Decode of the command word on the input channel.
    t_cmd               cmd;
    logic               accept;
    logic [WIDTH_W-1:0] width;
    logic [VALUE_W-1:0] mask;
    logic               fits;
    logic               pos_ok;
    logic [CW:0]        cur_sum;
    logic [CW:0]        aligned;
    logic [AW-1:0]      cur_addr;
    logic [OFF_W-1:0]   cur_off;
    logic [7:0]         span;
    logic               load_out;

    // Store and shifter connections.
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WORD_W-1:0]   wdata;
    logic [AW-1:0]       raddr;
    logic [WORD_W-1:0]   rdata;
    logic [2*WORD_W-1:0] sh_in;
    logic [SHAMT_W-1:0]  sh_amt;
    logic [WORD_W-1:0]   sh_out;

    assign cmd    = t_cmd'(i_cmd.command);
    assign accept = i_cmd.valid && i_cmd.ready;

    // Widths above the maximum saturate to the maximum.
    assign width = (i_cmd.field_width > WIDTH_W'(MAX_FIELD_BITS)) ?
                   WIDTH_W'(MAX_FIELD_BITS) : i_cmd.field_width;
    assign mask  = (width >= WIDTH_W'(VALUE_W)) ? {VALUE_W{1'b1}} :
                   ((VALUE_W'(1) << width) - VALUE_W'(1));

    assign cur_sum  = {1'b0, r_cursor} + (CW + 1)'(width);
    assign fits     = cur_sum <= (CW + 1)'(CAP);
    assign pos_ok   = PW'(i_cmd.new_position) <= PW'(CAP);
    assign aligned  = ({1'b0, r_cursor} + (CW + 1)'(7)) & ~(CW + 1)'(7);
    assign cur_addr = AW'(r_cursor >> OFF_W);
    assign cur_off  = r_cursor[OFF_W-1:0];
    // The field needs a second word when it runs past bit 63 of the first.
    assign span     = 8'(cur_off) + 8'(width);

    assign load_out = (r_state == S_DONE) && (!r_ov || o_res.ready);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                    if (fits && width != '0) begin
                        if (cmd == CMD_WRITE) begin
                            n_state = S_WR0;
                        end else if (cmd == CMD_READ) begin
                            n_state = S_RD1;
                        end
                    end
                end
            end
            S_WR0:  n_state = r_need ? S_WR1 : S_DONE;
            S_WR1:  n_state = S_DONE;
            S_RD1:  n_state = S_EXT;
            S_EXT:  n_state = S_DONE;
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // The shared funnel shifter. For a write, the low word gets the field
    // moved up by the offset and the high word gets what spills out of it.
    // For a read, the two words are moved down by the offset.
    always_comb begin
        sh_in  = {r_val, {WORD_W{1'b0}}};
        sh_amt = SHAMT_W'(WORD_W) - SHAMT_W'(r_off);
        case (r_state)
            S_WR1: begin
                sh_in = {{WORD_W{1'b0}}, r_val};
            end
            S_EXT: begin
                sh_in  = {(r_need ? rdata : {WORD_W{1'b0}}), r_lo};
                sh_amt = SHAMT_W'(r_off);
            end
            default: ;
        endcase
    end

    // Store port control. The first word is read in the accept cycle, the
    // second while the first is being written back, or in S_RD1 for a read.
    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = rdata | sh_out;
        raddr = cur_addr;
        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            S_WR0: begin
                we    = 1'b1;
                raddr = r_need ? r_addr + AW'(1) : r_addr;
            end
            S_WR1: begin
                we    = 1'b1;
                waddr = r_addr + AW'(1);
            end
            S_RD1: begin
                raddr = r_need ? r_addr + AW'(1) : r_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cursor <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            // Every cursor move is settled at acceptance; the word address
            // and offset of the old cursor are kept for the store accesses.
            if (accept) begin
                unique case (cmd)
                    CMD_WRITE, CMD_READ: begin
                        if (fits) begin
                            r_cursor <= cur_sum[CW-1:0];
                        end
                    end
                    CMD_ALIGN: r_cursor <= aligned[CW-1:0];
                    CMD_SET: begin
                        if (pos_ok) begin
                            r_cursor <= CW'(i_cmd.new_position);
                        end
                    end
                    default: ;
                endcase
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= cur_addr;
            r_off  <= cur_off;
            r_need <= span > 8'(WORD_W);
            r_val  <= i_cmd.field_value & mask;
            r_mask <= mask;
            r_rd   <= '0;
            if (cmd == CMD_SET) begin
                r_st <= !pos_ok;
            end else if (cmd == CMD_ALIGN) begin
                r_st <= 1'b0;
            end else begin
                r_st <= !fits;
            end
        end
        if (r_state == S_RD1) begin
            r_lo <= rdata;
        end
        if (r_state == S_EXT) begin
            r_rd <= sh_out & r_mask;
        end
        if (load_out) begin
            r_o_read   <= r_rd;
            r_o_cursor <= POS_W'(r_cursor);
            r_o_status <= r_st;
        end
    end

    lbfp_store #(
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lbfp_funnel u_funnel (
        .i_din   (sh_in),
        .i_shamt (sh_amt),
        .o_dout  (sh_out)
    );

    assign i_cmd.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_ov;
    assign o_res.read_value      = r_o_read;
    assign o_res.cursor_position = r_o_cursor;
    assign o_res.status          = r_o_status;

endmodule
`default_nettype wire

// ----- tb/tb_lsb_first_bit_field_packer.sv -----
// Testbench for the LSB-first bit-field packer. It sends command words with
// random idling and compares every result word against a shadow of the byte
// store and the bit cursor. Depends on lbfp_pkg, the lbfp interfaces and the RTL.
`default_nettype none
module tb_lsb_first_bit_field_packer;
    import lbfp_pkg::*;

    localparam int STORE_BYTES    = STORE_BYTES_DEF;
    localparam int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF;
    localparam int CAP_BITS       = STORE_BYTES * 8;
    // The clearing pass, and every word with the longest gap on each side, fit
    // far inside this limit, so it lies beyond the slowest correct run.
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_MAX     = 10;

    // One result word as the block presents it.
    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]   cursor_position;
        logic               status;
    } t_packer_result;

    logic clk;
    logic rst_n;

    lbfp_in_if  cmd_if ();
    lbfp_out_if res_if ();

    lsb_first_bit_field_packer #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Shadow copy of the block's state: the byte store and the bit cursor.
    bit [7:0]       shadow_bytes [STORE_BYTES];
    int unsigned    shadow_cursor;

    // Results owed by the block, oldest first.
    t_packer_result packer_results_q [$];

    int  words_sent;
    int  error_count;
    int  cycle_count;
    bit  idle_on = 1'b1;
    bit  sink_hold;
    event hold_kick;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The whole run is bounded by a plain cycle count. Reaching it means the
    // block hung somewhere, so it is a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one. With idling
    // switched off both sides run flat out.
    function automatic int pick_gap();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // Applies one command to the shadow state and returns the result word
    // that the block must produce for it. Widths above the maximum saturate,
    // and any write or read that would run past the capacity does nothing
    // but raise the overflow status.
    function automatic t_packer_result packer_step(input t_cmd op,
                                                   input logic [VALUE_W-1:0] value,
                                                   input logic [WIDTH_W-1:0] width,
                                                   input logic [POS_W-1:0] pos);
        t_packer_result res;
        int unsigned    nbits;
        int unsigned    bitpos;
        res   = '0;
        nbits = (width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : width;
        case (op)
            CMD_WRITE: begin
                if (shadow_cursor + nbits > CAP_BITS) begin
                    res.status = 1'b1;
                end else begin
                    // Bits are only ever ORed in, never cleared.
                    for (int i = 0; i < nbits; i++) begin
                        bitpos = shadow_cursor + i;
                        if (value[i]) shadow_bytes[bitpos / 8][bitpos % 8] = 1'b1;
                    end
                    shadow_cursor += nbits;
                end
            end
            CMD_READ: begin
                if (shadow_cursor + nbits > CAP_BITS) begin
                    res.status = 1'b1;
                end else begin
                    for (int i = 0; i < nbits; i++) begin
                        bitpos = shadow_cursor + i;
                        res.read_value[i] = shadow_bytes[bitpos / 8][bitpos % 8];
                    end
                    shadow_cursor += nbits;
                end
            end
            CMD_ALIGN: begin
                shadow_cursor = (shadow_cursor + 7) & ~32'd7;
            end
            default: begin
                if (pos > CAP_BITS) res.status = 1'b1;
                else shadow_cursor = pos;
            end
        endcase
        res.cursor_position = shadow_cursor[POS_W-1:0];
        return res;
    endfunction

    // Offers one command word and returns at the edge where it is accepted.
    // It is always entered right after a rising edge. Valid stays high from
    // one word to the next when there is no gap, so it is assigned at most
    // once in any time step.
    task automatic send_word(input t_cmd op, input logic [VALUE_W-1:0] value,
                             input logic [WIDTH_W-1:0] width,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= op;
        cmd_if.field_value  <= value;
        cmd_if.field_width  <= width;
        cmd_if.new_position <= pos;
        do @(posedge clk); while (!cmd_if.ready);
        packer_results_q.push_back(packer_step(op, value, width, pos));
        words_sent++;
    endtask

    // Drops valid and waits until every owed result word has arrived.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (packer_results_q.size() != 0);
    endtask

    // Compares one accepted result word with the oldest owed one.
    task automatic check_result();
        t_packer_result want;
        t_packer_result got;
        got = '{res_if.read_value, res_if.cursor_position, res_if.status};
        if (packer_results_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("unexpected result word: read_value %h cursor %0d status %0d",
                         got.read_value, got.cursor_position, got.status);
        end else begin
            want = packer_results_q.pop_front();
            if (got !== want) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display({"mismatch: read_value exp %h got %h, cursor exp %0d got %0d,",
                              " status exp %0d got %0d"},
                             want.read_value, got.read_value,
                             want.cursor_position, got.cursor_position,
                             want.status, got.status);
            end
        end
    endtask

    // Result side: samples the handshake at each edge, then decides whether
    // to accept in the next cycle. Random stalls start on a one-in-four roll,
    // and a long hold from the hold timer overrides everything.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready) check_result();
            if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            res_if.ready <= !(sink_hold || stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Long receiver hold-off, counted here so that the sender can keep
    // offering words while it lasts.
    initial begin : hold_timer
        sink_hold <= 1'b0;
        forever begin
            @(hold_kick);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    // Widest and narrowest fields, zero width, saturated width, and align
    // both off and on a byte boundary.
    task automatic test_field_extremes();
        send_word(CMD_WRITE, 64'd1, 7'd1, 16'($urandom));
        send_word(CMD_WRITE, '1, 7'd64, 16'($urandom));
        send_word(CMD_WRITE, rand_value(), 7'd0, 16'($urandom));
        send_word(CMD_WRITE, rand_value(), 7'd127, 16'($urandom));
        send_word(CMD_ALIGN, rand_value(), 7'($urandom), 16'($urandom));
        send_word(CMD_ALIGN, rand_value(), 7'($urandom), 16'($urandom));
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'd0);
        send_word(CMD_READ, rand_value(), 7'd1, 16'($urandom));
        send_word(CMD_READ, rand_value(), 7'd64, 16'($urandom));
        send_word(CMD_READ, rand_value(), 7'd0, 16'($urandom));
        send_word(CMD_READ, rand_value(), 7'd100, 16'($urandom));
    endtask

    // A write of zeros over set bits must leave them set, and value bits
    // above the field width must not reach the store.
    task automatic test_or_semantics();
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'd0);
        send_word(CMD_WRITE, 64'd0, 7'd8, 16'($urandom));
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'd0);
        send_word(CMD_READ, rand_value(), 7'd16, 16'($urandom));
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'd200);
        send_word(CMD_WRITE, '1, 7'd4, 16'($urandom));
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'd200);
        send_word(CMD_READ, rand_value(), 7'd8, 16'($urandom));
    endtask

    // Cursor at the capacity, fields that would run past it, and cursor
    // loads beyond it.
    task automatic test_capacity_edges();
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'(CAP_BITS));
        send_word(CMD_WRITE, '1, 7'd1, 16'($urandom));
        send_word(CMD_READ, rand_value(), 7'd1, 16'($urandom));
        send_word(CMD_ALIGN, rand_value(), 7'($urandom), 16'($urandom));
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'(CAP_BITS + 1));
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'hFFFF);
        send_word(CMD_SET, rand_value(), 7'($urandom), 16'(CAP_BITS - 8));
        send_word(CMD_WRITE, '1, 7'd64, 16'($urandom));
        send_word(CMD_WRITE, '1, 7'd8, 16'($urandom));
    endtask

    function automatic logic [WIDTH_W-1:0] pick_width();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 7'd0;
        if (roll == 1) return 7'($urandom_range(65, 127));
        return 7'($urandom_range(1, 64));
    endfunction

    function automatic logic [POS_W-1:0] pick_base();
        if ($urandom_range(0, 4) == 0) return 16'($urandom_range(CAP_BITS - 200, CAP_BITS));
        return 16'($urandom_range(0, CAP_BITS - 1));
    endfunction

    // A well-formed record: place the cursor, pack a few fields with the odd
    // align between them, go back and unpack them the same way. Now and then
    // a field is read back at a different width.
    task automatic send_record();
        logic [POS_W-1:0]   base;
        logic [WIDTH_W-1:0] widths [6];
        bit                 aligned [6];
        int                 nfields;
        base    = pick_base();
        nfields = $urandom_range(1, 6);
        send_word(CMD_SET, rand_value(), 7'($urandom), base);
        for (int i = 0; i < nfields; i++) begin
            widths[i]  = pick_width();
            aligned[i] = ($urandom_range(0, 7) == 0);
            if (aligned[i]) send_word(CMD_ALIGN, rand_value(), 7'($urandom), 16'($urandom));
            send_word(CMD_WRITE, rand_value(), widths[i], 16'($urandom));
        end
        send_word(CMD_SET, rand_value(), 7'($urandom), base);
        for (int i = 0; i < nfields; i++) begin
            if (aligned[i]) send_word(CMD_ALIGN, rand_value(), 7'($urandom), 16'($urandom));
            if ($urandom_range(0, 7) == 0) widths[i] = pick_width();
            send_word(CMD_READ, rand_value(), widths[i], 16'($urandom));
        end
    endtask

    // Noise: any command with any field values, including cursor loads
    // anywhere in the 16-bit range.
    task automatic send_noise();
        logic [POS_W-1:0] pos;
        pos = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, CAP_BITS))
                                          : 16'($urandom);
        send_word(t_cmd'($urandom_range(0, 3)), rand_value(), 7'($urandom), pos);
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 3) != 0) send_record();
            else repeat ($urandom_range(1, 4)) send_noise();
        end
    endtask

    // Both sides flat out, no idling at all.
    task automatic test_back_to_back(input int count);
        idle_on <= 1'b0;
        test_random_traffic(count);
        idle_on <= 1'b1;
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the block fills up and drops its input ready. Then
    // the sender pauses until every result word is back.
    task automatic test_backpressure();
        idle_on <= 1'b0;
        -> hold_kick;
        repeat (40) send_noise();
        wait_drained();
        idle_on <= 1'b1;
    endtask

    initial begin : stimulus
        words_sent  = 0;
        error_count = 0;
        shadow_cursor = 0;
        foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
        rst_n               <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.command      <= CMD_WRITE;
        cmd_if.field_value  <= '0;
        cmd_if.field_width  <= '0;
        cmd_if.new_position <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its store after reset with input ready low; the
        // first word simply waits for that to finish.
        test_field_extremes();
        test_or_semantics();
        test_capacity_edges();
        test_backpressure();
        test_random_traffic(1080);
        test_back_to_back(150);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
